FILE: rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the websocket frame deframer.
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_LEN16 = 3'd2,
      PH_LEN64 = 3'd3,
      PH_MASK  = 3'd4,
      PH_PAY   = 3'd5
   } wsd_phase_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_FRAGMENT = 3'd1,
      ACT_MESSAGE  = 3'd2,
      ACT_CLOSE    = 3'd3,
      ACT_PING     = 3'd4,
      ACT_PONG     = 3'd5
   } wsd_action_type;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;
   localparam logic [3:0] LEN16_BYTES = 4'd2;
   localparam logic [3:0] LEN64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic           valid;
      logic [7:0]     data_byte;
      logic           data_valid;
      logic [3:0]     frame_opcode;
      logic           frame_fin;
      logic           frame_end;
      wsd_action_type action;
   } wsd_result_type;

endpackage

FILE: rtl/websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
// Websocket frame deframer top level: input handshake, config register, result register.
//
// The req_ channel carries the received frame stream, one byte per transaction.
// The rsp_ channel carries at most one result per input byte: an unmasked
// payload byte, or a header-only frame end when the payload is empty. The
// last result of each frame has rsp_frame_end set and an rsp_action code.
// Header bytes that do not end a frame produce no result.
// A result is registered and appears on rsp_ in the cycle after its byte is accepted.
// One byte is accepted per cycle while no pending result is held by rsp_stall; the
// single decode stage lies between the parser state and the result register.
// While a pending result is held by rsp_stall, req_stall stays high; a byte
// is still accepted in the cycle the result is taken.
// csr_write_enable writes ping_pong_enable; write it only while idle.
// Reset (synchronous, active high) returns the parser to the first header
// byte, empties the result register and sets ping_pong_enable to 1.
module websocket_frame_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_data_valid,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_frame_fin,
   output logic       rsp_frame_end,
   output logic [2:0] rsp_action,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import wsd_pkg::*;

   logic           ppen_ff;
   logic           valid_ff, valid_in;
   wsd_result_type result;
   wsd_result_type out_ff;
   logic           accept;

   assign req_stall = valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   wsd_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .step             (accept),
      .rx_byte          (req_rx_byte),
      .ping_pong_enable (ppen_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ppen_ff <= 1'b1;
      end else if (csr_write_enable) begin
         ppen_ff <= csr_write_data;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = result.valid;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_data_valid   = out_ff.data_valid;
   assign rsp_frame_opcode = out_ff.frame_opcode;
   assign rsp_frame_fin    = out_ff.frame_fin;
   assign rsp_frame_end    = out_ff.frame_end;
   assign rsp_action       = 3'(out_ff.action);

endmodule

FILE: rtl/wsd_parse.sv
`timescale 1ns / 1ps
// Header decode, length and mask tracking, and payload unmasking for one byte.
module wsd_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   input  logic                    ping_pong_enable,
   output wsd_pkg::wsd_result_type result
);
   import wsd_pkg::*;

   wsd_phase_type phase_ff, phase_in;
   logic          fin_ff, fin_in;
   logic [3:0]    opcode_ff, opcode_in;
   logic          masked_ff, masked_in;
   logic [3:0]    count_ff, count_in;
   logic [63:0]   remain_ff, remain_in;
   logic [31:0]   key_ff, key_in;
   logic [1:0]    index_ff, index_in;

   logic [3:0]     count_inc;
   logic [3:0]     need;
   logic [63:0]    remain_shift;
   logic [7:0]     key_byte;
   wsd_action_type end_action;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         fin_ff    <= 1'b0;
         opcode_ff <= 4'd0;
         masked_ff <= 1'b0;
         count_ff  <= 4'd0;
         remain_ff <= 64'd0;
         key_ff    <= 32'd0;
         index_ff  <= 2'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         key_ff    <= key_in;
         index_ff  <= index_in;
      end
   end

   always_comb begin
      if (opcode_ff == OP_CLOSE) begin
         end_action = ACT_CLOSE;
      end else if (ping_pong_enable && opcode_ff == OP_PING) begin
         end_action = ACT_PING;
      end else if (ping_pong_enable && opcode_ff == OP_PONG) begin
         end_action = ACT_PONG;
      end else if (fin_ff) begin
         end_action = ACT_MESSAGE;
      end else begin
         end_action = ACT_FRAGMENT;
      end
   end

   always_comb begin
      case (index_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign count_inc    = count_ff + 4'd1;
   assign need         = (phase_ff == PH_LEN16) ? LEN16_BYTES : LEN64_BYTES;
   assign remain_shift = {remain_ff[55:0], rx_byte};

   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      key_in    = key_ff;
      index_in  = index_ff;

      result.valid        = 1'b0;
      result.data_byte    = 8'd0;
      result.data_valid   = 1'b0;
      result.frame_opcode = opcode_ff;
      result.frame_fin    = fin_ff;
      result.frame_end    = 1'b0;
      result.action       = ACT_NONE;

      case (phase_ff)
         PH_HDR1: begin
            masked_in = rx_byte[7];
            count_in  = 4'd0;
            remain_in = 64'd0;
            if (rx_byte[6:0] == LEN_EXT16) begin
               phase_in = PH_LEN16;
            end else if (rx_byte[6:0] == LEN_EXT64) begin
               phase_in = PH_LEN64;
            end else begin
               remain_in = {57'd0, rx_byte[6:0]};
               if (rx_byte[7]) begin
                  phase_in = PH_MASK;
               end else if (rx_byte[6:0] == 7'd0) begin
                  phase_in         = PH_HDR0;
                  result.valid     = 1'b1;
                  result.frame_end = 1'b1;
                  result.action    = end_action;
               end else begin
                  phase_in = PH_PAY;
               end
            end
         end
         PH_LEN16, PH_LEN64: begin
            remain_in = remain_shift;
            count_in  = count_inc;
            if (count_inc >= need) begin
               if (masked_ff) begin
                  phase_in = PH_MASK;
                  count_in = 4'd0;
               end else if (remain_shift == 64'd0) begin
                  phase_in         = PH_HDR0;
                  result.valid     = 1'b1;
                  result.frame_end = 1'b1;
                  result.action    = end_action;
               end else begin
                  phase_in = PH_PAY;
               end
            end
         end
         PH_MASK: begin
            key_in   = {key_ff[23:0], rx_byte};
            count_in = count_inc;
            if (count_inc >= KEY_BYTES) begin
               if (remain_ff == 64'd0) begin
                  phase_in         = PH_HDR0;
                  result.valid     = 1'b1;
                  result.frame_end = 1'b1;
                  result.action    = end_action;
               end else begin
                  phase_in = PH_PAY;
               end
            end
         end
         PH_PAY: begin
            index_in          = index_ff + 2'd1;
            remain_in         = remain_ff - 64'd1;
            result.valid      = 1'b1;
            result.data_valid = 1'b1;
            result.data_byte  = masked_ff ? (rx_byte ^ key_byte) : rx_byte;
            if (remain_ff == 64'd1) begin
               phase_in         = PH_HDR0;
               result.frame_end = 1'b1;
               result.action    = end_action;
            end
         end
         default: begin
            fin_in    = rx_byte[7];
            opcode_in = rx_byte[3:0];
            masked_in = 1'b0;
            key_in    = 32'd0;
            index_in  = 2'd0;
            count_in  = 4'd0;
            remain_in = 64'd0;
            phase_in  = PH_HDR1;
         end
      endcase
   end

endmodule

FILE: rtl/wsd_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the websocket frame deframer, bound to the top level.
module wsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_data_valid,
   input logic       rsp_frame_end,
   input logic [2:0] rsp_action
);
   import wsd_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte) &&
         $stable(rsp_action))
      else $error("stalled result changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_valid |-> rsp_data_byte == 8'd0 && rsp_frame_end)
      else $error("header-only result malformed");

   a_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_end == (rsp_action != 3'(ACT_NONE))) &&
         (rsp_action <= 3'(ACT_PONG)))
      else $error("action does not match frame end");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_data_valid (rsp_data_valid),
   .rsp_frame_end  (rsp_frame_end),
   .rsp_action     (rsp_action)
);
